// ----- hdl/pnguf_pkg.sv -----
`default_nettype none

package pnguf_pkg;

    // line store and pixel history sizes
    localparam int MAX_ROW_BYTES = 131072;
    localparam int MAX_BPP       = 8;

    localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
    localparam int SLOT_W = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
    localparam int BACK_W = SLOT_W + 2;

    // register widths
    localparam int ROW_LEN_W  = 18;
    localparam int BPP_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;

    // width for comparing a row position against the row length
    localparam int CNT_W = (ADDR_W + 1 > ROW_LEN_W) ? ADDR_W + 1 : ROW_LEN_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_LENGTH      = 1'b0,
        REG_BYTES_PER_PIXEL = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    // one byte on its way from the line store read to the output register
    typedef struct packed {
        logic                bad;
        filter_t             filter;
        logic                first_row;
        logic                use_left;
        logic [SLOT_W-1:0]   slot;
        logic [SLOT_W-1:0]   back;
        logic                last;
        logic [7:0]          data;
        logic [ADDR_W-1:0]   pos;
    } work_t;

endpackage

`default_nettype wire

// ----- hdl/pnguf_ram.sv -----
`default_nettype none

module pnguf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, data held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/pnguf_predict.sv -----
`default_nettype none

module pnguf_predict
    import pnguf_pkg::*;
(
    input  filter_t    filter,
    input  logic [7:0] left,
    input  logic [7:0] above,
    input  logic [7:0] above_left,
    input  logic [7:0] data,
    output logic [7:0] value
);

    logic signed [9:0] d_left;
    logic signed [9:0] d_above;
    logic signed [9:0] d_corner;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    logic [8:0]        avg_sum;
    logic [7:0]        paeth;
    logic [7:0]        pred;

    // paeth distances: |b-c|, |a-c|, |a+b-2c|
    always_comb
    begin
        d_left   = $signed({2'b00, above}) - $signed({2'b00, above_left});
        d_above  = $signed({2'b00, left}) - $signed({2'b00, above_left});
        d_corner = d_left + d_above;
        pa = d_left[9] ? 10'(-d_left) : 10'(d_left);
        pb = d_above[9] ? 10'(-d_above) : 10'(d_above);
        pc = d_corner[9] ? 10'(-d_corner) : 10'(d_corner);
        if ((pa <= pb) && (pa <= pc))
        begin
            paeth = left;
        end
        else if (pb <= pc)
        begin
            paeth = above;
        end
        else
        begin
            paeth = above_left;
        end
    end

    // predictor select and add
    always_comb
    begin
        avg_sum = {1'b0, left} + {1'b0, above};
        case (filter)
            FILT_SUB:   pred = left;
            FILT_UP:    pred = above;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth;
            default:    pred = 8'd0;
        endcase
        value = data + pred;
    end

endmodule

`default_nettype wire

// ----- hdl/png_scanline_unfilter.sv -----
// a data byte taken is registered in the work stage, then in the output register
// throughput: one byte per clock, filter bytes included, while out_ready does not stall
//   the output; the line store is one memory with one write and one registered read port per cycle
// a line store entry is read one row after it was written, a filter byte between
// reset: control state, registers and pixel history cleared at once; the line store
//   is not cleared and needs no sweep, so the block accepts bytes right after reset
`default_nettype none

module png_scanline_unfilter
    import pnguf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            stream_byte,
    input  logic                  frame_start,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            pixel_byte,
    output logic                  row_end,
    output logic                  bad_filter,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [ROW_LEN_W-1:0] row_length_reg;
    logic [BPP_W-1:0]     bpp_reg;

    logic                 in_row_reg, in_row_next;
    logic                 first_row_reg, first_row_next;
    logic                 halted_reg, halted_next;
    filter_t              filter_reg, filter_next;
    logic [ADDR_W-1:0]    pos_reg, pos_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;

    logic                 work_valid_reg;
    work_t                work_reg;
    work_t                work_next;
    logic                 work_load;

    logic                 out_valid_reg;
    logic [7:0]           pixel_reg;
    logic                 row_end_reg;
    logic                 bad_reg;

    logic [7:0]           left_hist_reg [MAX_BPP];
    logic [7:0]           corner_hist_reg [MAX_BPP];

    logic                 in_fire;
    logic                 advance;
    logic                 commit;
    logic                 in_row_eff;
    logic                 halted_eff;
    logic [CNT_W-1:0]     len_ext;
    logic [CNT_W-1:0]     len_eff;
    logic [BPP_W-1:0]     bpp_eff;
    logic [BACK_W-1:0]    back_sum;
    logic [BACK_W-1:0]    back_wrap;
    logic                 last_byte;

    logic [7:0]           ram_rdata;
    logic [7:0]           above_b;
    logic [7:0]           left_a;
    logic [7:0]           corner_c;
    logic [7:0]           value;

    // handshake
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !work_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;
    assign commit   = work_valid_reg && advance && !work_reg.bad;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= ROW_LEN_W'(1);
            bpp_reg        <= BPP_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ROW_LENGTH:      row_length_reg <= cfg_data[ROW_LEN_W-1:0];
                REG_BYTES_PER_PIXEL: bpp_reg <= cfg_data[BPP_W-1:0];
                default:             ;
            endcase
        end
    end

    // clamped row length and pixel size
    always_comb
    begin
        len_ext = CNT_W'(row_length_reg);
        if (len_ext == '0)
        begin
            len_eff = CNT_W'(1);
        end
        else if (len_ext > CNT_W'(MAX_ROW_BYTES))
        begin
            len_eff = CNT_W'(MAX_ROW_BYTES);
        end
        else
        begin
            len_eff = len_ext;
        end
        if (bpp_reg == '0)
        begin
            bpp_eff = BPP_W'(1);
        end
        else if (bpp_reg > BPP_W'(MAX_BPP))
        begin
            bpp_eff = BPP_W'(MAX_BPP);
        end
        else
        begin
            bpp_eff = bpp_reg;
        end
        back_sum  = BACK_W'(slot_reg) + BACK_W'(MAX_BPP) - BACK_W'(bpp_eff);
        back_wrap = (back_sum >= BACK_W'(MAX_BPP)) ? back_sum - BACK_W'(MAX_BPP) : back_sum;
        last_byte = (CNT_W'(pos_reg) + CNT_W'(1)) >= len_eff;
    end

    // row control, decided as the byte is taken
    always_comb
    begin
        in_row_eff     = frame_start ? 1'b0 : in_row_reg;
        halted_eff     = frame_start ? 1'b0 : halted_reg;
        in_row_next    = in_row_reg;
        first_row_next = first_row_reg;
        halted_next    = halted_reg;
        filter_next    = filter_reg;
        pos_next       = pos_reg;
        slot_next      = slot_reg;
        work_load      = 1'b0;

        work_next.bad       = 1'b0;
        work_next.filter    = filter_reg;
        work_next.first_row = first_row_reg;
        work_next.use_left  = CNT_W'(pos_reg) >= CNT_W'(bpp_eff);
        work_next.slot      = slot_reg;
        work_next.back      = back_wrap[SLOT_W-1:0];
        work_next.last      = last_byte;
        work_next.data      = stream_byte;
        work_next.pos       = pos_reg;

        if (in_fire)
        begin
            if (frame_start)
            begin
                in_row_next    = 1'b0;
                first_row_next = 1'b1;
                halted_next    = 1'b0;
                filter_next    = FILT_NONE;
            end
            if (!halted_eff)
            begin
                if (!in_row_eff)
                begin
                    if (stream_byte > 8'(FILT_PAETH))
                    begin
                        halted_next   = 1'b1;
                        work_load     = 1'b1;
                        work_next.bad = 1'b1;
                    end
                    else
                    begin
                        filter_next = filter_t'(stream_byte[2:0]);
                        in_row_next = 1'b1;
                        pos_next    = '0;
                        slot_next   = '0;
                    end
                end
                else
                begin
                    work_load = 1'b1;
                    if (last_byte)
                    begin
                        in_row_next    = 1'b0;
                        first_row_next = 1'b0;
                    end
                    else
                    begin
                        pos_next  = pos_reg + ADDR_W'(1);
                        slot_next = (slot_reg == SLOT_W'(MAX_BPP - 1)) ?
                                    '0 : slot_reg + SLOT_W'(1);
                    end
                end
            end
        end
    end

    // row control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg    <= 1'b0;
            first_row_reg <= 1'b1;
            halted_reg    <= 1'b0;
            filter_reg    <= FILT_NONE;
            pos_reg       <= '0;
            slot_reg      <= '0;
        end
        else
        begin
            in_row_reg    <= in_row_next;
            first_row_reg <= first_row_next;
            halted_reg    <= halted_next;
            filter_reg    <= filter_next;
            pos_reg       <= pos_next;
            slot_reg      <= slot_next;
        end
    end

    // work stage, waits for the line store read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            work_valid_reg <= in_fire && work_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            work_reg <= work_next;
        end
    end

    // line store of the previous row
    pnguf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line (
        .clk   (clk),
        .we    (commit),
        .waddr (work_reg.pos),
        .wdata (value),
        .re    (in_fire),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    // neighbour bytes
    always_comb
    begin
        above_b  = work_reg.first_row ? 8'd0 : ram_rdata;
        left_a   = work_reg.use_left ? left_hist_reg[work_reg.back] : 8'd0;
        corner_c = (work_reg.use_left && !work_reg.first_row) ?
                   corner_hist_reg[work_reg.back] : 8'd0;
    end

    pnguf_predict u_predict (
        .filter     (work_reg.filter),
        .left       (left_a),
        .above      (above_b),
        .above_left (corner_c),
        .data       (work_reg.data),
        .value      (value)
    );

    // pixel history, cleared by a frame start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BPP; i++)
            begin
                left_hist_reg[i]   <= 8'd0;
                corner_hist_reg[i] <= 8'd0;
            end
        end
        else if (in_fire && frame_start)
        begin
            for (int i = 0; i < MAX_BPP; i++)
            begin
                left_hist_reg[i]   <= 8'd0;
                corner_hist_reg[i] <= 8'd0;
            end
        end
        else if (commit)
        begin
            left_hist_reg[work_reg.slot]   <= value;
            corner_hist_reg[work_reg.slot] <= above_b;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= work_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && work_valid_reg)
        begin
            pixel_reg   <= work_reg.bad ? 8'd0 : value;
            row_end_reg <= !work_reg.bad && work_reg.last;
            bad_reg     <= work_reg.bad;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_byte = pixel_reg;
    assign row_end    = row_end_reg;
    assign bad_filter = bad_reg;

endmodule

`default_nettype wire

// ----- hdl/pnguf_checker.sv -----
`default_nettype none

module pnguf_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [7:0]            pixel_byte,
    input wire logic                  row_end,
    input wire logic                  bad_filter
);

    // no result while in reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result shown during reset");

    // an error result carries no pixel and no row end
    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_filter |-> pixel_byte == 8'd0 && !row_end)
        else $error("error result with data");

    // a fresh result follows an input transfer through the work stage
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without an input transfer");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_byte)
            && $stable(row_end) && $stable(bad_filter))
        else $error("stalled result changed");

endmodule

bind png_scanline_unfilter pnguf_checker u_pnguf_checker (.*);

`default_nettype wire
